FILE: rtl/address_set_linear_probe_top_defines.svh
// Assertion macros used by the address set controller.
`ifndef ADDRESS_SET_LINEAR_PROBE_TOP_DEFINES_SVH
`define ADDRESS_SET_LINEAR_PROBE_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define ALP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define ALP_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

FILE: rtl/alp_pkg.sv
// Types and constants shared by the address set controller, datapath and top level.
package alp_pkg;

  localparam int OP_W   = 2;
  localparam int LEN_W  = 4;
  localparam int KEY_W  = 64;
  localparam int SLOT_W = 10;

  // Request operation codes; the unused code behaves as a lookup
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [LEN_W-1:0] key_length;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              full_res;
  } res_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic clr_we;
    logic ins_we;
    logic del_we;
    logic step;
    logic res_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic rd_valid;
    logic rd_match;
    logic probe_last;
    logic op_insert;
    logic op_delete;
  } dp_status_t;

endpackage

FILE: rtl/address_set_linear_probe_top.sv
// Each probe of a request is one read of the single-port table RAM plus a compare; a
// request probes one slot for a short chain and up to BUCKETS slots in the worst case.
// Busy stays high while a request probes, so a new request waits until the last is done.
// Reset: synchronous, active low; a clearing pass then writes every slot empty, with busy
// high. The receiver cannot stall; each result shows for exactly one cycle on out_valid.
module address_set_linear_probe_top #(
  parameter int BUCKETS   = 1024,
  parameter int KEY_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  alp_pkg::req_t in_req,
  output logic          out_valid,
  output alp_pkg::res_t out_res
);
  import alp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  alp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .status(status),
    .cmd   (cmd)
  );

  alp_dp #(
    .BUCKETS  (BUCKETS),
    .KEY_BYTES(KEY_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

endmodule

FILE: rtl/alp_ram.sv
// Single-port RAM with registered read data.
module alp_ram #(
  parameter int WIDTH = 69,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on enable, register the read word every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/alp_ctrl.sv
// Controller state machine: clearing pass, request accept and probe sequencing.
`include "address_set_linear_probe_top_defines.svh"

module alp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  alp_pkg::dp_status_t status,
  output alp_pkg::dp_cmd_t    cmd
);
  import alp_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Decode the next state and the datapath commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.rd_valid && status.rd_match) begin
          // key present: drop it on delete
          cmd.res_load = 1'b1;
          cmd.del_we   = status.op_delete;
          state_nxt    = ST_IDLE;
        end else if (!status.rd_valid) begin
          // empty slot ends the chain: claim it on insert
          cmd.res_load = 1'b1;
          cmd.ins_we   = status.op_insert;
          state_nxt    = ST_IDLE;
        end else if (status.probe_last) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Hold the state; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  `ALP_ASSERT_NEXT(a_accept_reads, start && !busy, state_r == ST_READ, "accepted request did not start a probe")
  `ALP_ASSERT(a_one_write, ($onehot0({cmd.clr_we, cmd.ins_we, cmd.del_we})), "more than one table write")
  `ALP_ASSERT_NEXT(a_store_ends, cmd.ins_we || cmd.del_we, state_r == ST_IDLE, "table update did not end the request")
  `ALP_ASSERT(a_result_check, !cmd.res_load || state_r == ST_CHECK, "result loaded outside the check step")

endmodule

FILE: rtl/alp_dp.sv
// Datapath: key masking, home slot hash, probe index, table RAM and result register.
module alp_dp #(
  parameter int BUCKETS   = 1024,
  parameter int KEY_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  alp_pkg::req_t       in_req,
  input  alp_pkg::dp_cmd_t    cmd,
  output alp_pkg::dp_status_t status,
  output logic                out_valid,
  output alp_pkg::res_t       out_res
);
  import alp_pkg::*;

  localparam int IDX_W  = $clog2(BUCKETS);
  localparam int SKEY_W = KEY_BYTES * 8;
  localparam int ENT_W  = 1 + LEN_W + SKEY_W;
  localparam int HASH_N = 256;

  // Home slot table: 8-bit hash folded into the bucket range
  logic [IDX_W-1:0] home_lut [HASH_N];
  for (genvar g = 0; g < HASH_N; g++) begin : g_home
    assign home_lut[g] = IDX_W'(g % BUCKETS);
  end

  logic [LEN_W-1:0]  len_sat;
  logic [SKEY_W-1:0] key_msk;
  logic [7:0]        hash;

  // Saturate the length, zero unused bytes and fold the key
  always_comb begin
    len_sat = (in_req.key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                      : in_req.key_length;
    key_msk = '0;
    hash    = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (LEN_W'(b) < len_sat) begin
        key_msk[b*8 +: 8] = in_req.key[b*8 +: 8];
      end
      hash = hash ^ key_msk[b*8 +: 8];
    end
  end

  logic [OP_W-1:0]   op_r;
  logic [LEN_W-1:0]  len_r;
  logic [SKEY_W-1:0] key_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  pcnt_r;
  logic [IDX_W-1:0]  clr_r;
  logic              out_valid_r;
  res_t              res_r;
  logic [IDX_W-1:0]  idx_inc;

  assign idx_inc = (idx_r == IDX_W'(BUCKETS - 1)) ? '0 : IDX_W'(idx_r + 1'b1);

  // Latch the request, then advance the probe with wrap
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_req.operation;
      len_r  <= len_sat;
      key_r  <= key_msk;
      idx_r  <= home_lut[hash];
      pcnt_r <= '0;
    end else if (cmd.step) begin
      idx_r  <= idx_inc;
      pcnt_r <= IDX_W'(pcnt_r + 1'b1);
    end
  end

  // Sweep the table once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_we) begin
      clr_r <= IDX_W'(clr_r + 1'b1);
    end
  end

  // Table RAM: {valid, length, key} per slot
  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;
  logic              rd_valid;
  logic [LEN_W-1:0]  rd_len;
  logic [SKEY_W-1:0] rd_key;
  logic              rd_match;

  assign ram_we    = cmd.clr_we | cmd.ins_we | cmd.del_we;
  assign ram_addr  = cmd.clr_we ? clr_r : idx_r;
  assign ram_wdata = cmd.ins_we ? {1'b1, len_r, key_r} : '0;

  alp_ram #(
    .WIDTH(ENT_W),
    .DEPTH(BUCKETS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign rd_valid = ram_rdata[ENT_W-1];
  assign rd_len   = ram_rdata[ENT_W-2 -: LEN_W];
  assign rd_key   = ram_rdata[SKEY_W-1:0];
  assign rd_match = (rd_len == len_r) && (rd_key == key_r);

  always_comb begin
    status            = '0;
    status.clr_last   = (clr_r == IDX_W'(BUCKETS - 1));
    status.rd_valid   = rd_valid;
    status.rd_match   = rd_match;
    status.probe_last = (pcnt_r == IDX_W'(BUCKETS - 1));
    status.op_insert  = (op_r == OP_INSERT);
    status.op_delete  = (op_r == OP_DELETE);
  end

  // Register the result for a one-cycle strobe
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r.hit      <= rd_valid && rd_match;
      res_r.slot     <= ((rd_valid && rd_match) || (!rd_valid && status.op_insert))
                        ? SLOT_W'(idx_r) : '0;
      res_r.full_res <= status.op_insert && rd_valid && !rd_match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_load;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

FILE: tb/sv/tb_address_set_linear_probe_top.sv
// Self-checking testbench for the linear-probe address set: directed table and random requests.
module tb_address_set_linear_probe_top;
  timeunit 1ns;
  timeprecision 1ps;

  import alp_pkg::*;

  localparam int BUCKETS   = 1024;
  localparam int KEY_BYTES = 8;
  localparam int ITEMS_PER_PHASE = 234;
  localparam int POOL_MAX  = 48;

  // Spare operation code, which the block answers as a lookup
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [LEN_W-1:0]  len;
    logic [KEY_W-1:0]  key;
    logic              typed;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } dir_row_t;

  // Directed requests; rows with typed set carry their own answer
  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_LOOKUP, 4'd0,  64'h0,                   1'b1, 1'b0, 10'd0},   // empty table
    '{OP_INSERT, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 10'd0},   // zero-length key
    '{OP_LOOKUP, 4'd0,  64'h1234,                1'b1, 1'b1, 10'd0},
    '{OP_INSERT, 4'd1,  64'hFFFF_FFFF_FFFF_FF00, 1'b1, 1'b0, 10'd1},   // same home, new length
    '{OP_INSERT, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 10'd2},
    '{OP_LOOKUP, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 10'd2},   // length saturates
    '{OP_INSERT, 4'd1,  64'h00FF,                1'b1, 1'b0, 10'd255},
    '{OP_INSERT, 4'd2,  64'h00FF,                1'b1, 1'b0, 10'd256},
    '{OP_SPARE,  4'd2,  64'hABCD_00FF,           1'b1, 1'b1, 10'd256}, // spare op looks up
    '{OP_INSERT, 4'd1,  64'h00FF,                1'b1, 1'b1, 10'd255}, // already present
    '{OP_DELETE, 4'd1,  64'hFF,                  1'b1, 1'b1, 10'd255},
    '{OP_LOOKUP, 4'd2,  64'h00FF,                1'b1, 1'b0, 10'd0},   // hole hides the entry
    '{OP_DELETE, 4'd2,  64'h00FF,                1'b1, 1'b0, 10'd0},
    '{OP_INSERT, 4'd3,  64'h12_3456,             1'b0, 1'b0, 10'd0},
    '{OP_INSERT, 4'd4,  64'h8040_2010,           1'b0, 1'b0, 10'd0},
    '{OP_LOOKUP, 4'd5,  64'hFF_8040_2010,        1'b0, 1'b0, 10'd0},
    '{OP_INSERT, 4'd8,  64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 10'd0},
    '{OP_DELETE, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 10'd2},
    '{OP_LOOKUP, 4'd0,  64'h0,                   1'b1, 1'b1, 10'd0},
    '{OP_LOOKUP, 4'd1,  64'h5500,                1'b1, 1'b1, 10'd1},
    '{OP_INSERT, 4'd9,  64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 10'd0},
    '{OP_DELETE, 4'd0,  64'hDEAD,                1'b1, 1'b1, 10'd0},
    '{OP_LOOKUP, 4'd1,  64'h0,                   1'b1, 1'b0, 10'd0}    // hole at home
  };

  logic  clk;
  logic  rst_n  = 1'b0;
  logic  start  = 1'b0;
  req_t  in_req = '0;
  logic  busy;
  logic  out_valid;
  res_t  out_res;

  // Shadow copy of the table
  bit               slot_used [BUCKETS];
  logic [LEN_W-1:0] slot_len  [BUCKETS];
  logic [KEY_W-1:0] slot_key  [BUCKETS];
  int               occupied = 0;
  int               peak_occupied = 0;

  // Answers still owed by the block, oldest first
  res_t             expected_res [$];
  res_t             head_res;

  // Keys seen in inserts, reused so that hits and deletes are common
  logic [KEY_W-1:0] pool_key [$];
  logic [LEN_W-1:0] pool_len [$];

  int unsigned idle_pct = 0;
  int          errors   = 0;
  int          n_sent   = 0;
  int          n_results = 0;
  int          n_hits   = 0;
  int          n_full   = 0;

  address_set_linear_probe_top #(
    .BUCKETS   (BUCKETS),
    .KEY_BYTES (KEY_BYTES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Keep the low len bytes of a key, zero the rest
  function automatic logic [KEY_W-1:0] masked_key(logic [KEY_W-1:0] k, int unsigned len);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < len && i < KEY_BYTES; i++) m[8*i +: 8] = k[8*i +: 8];
    return m;
  endfunction

  // Apply one request to the shadow table and return the answer it earns
  function automatic res_t apply_request(req_t r);
    res_t             res;
    logic [LEN_W-1:0] len;
    logic [KEY_W-1:0] k;
    int unsigned      home;
    int unsigned      idx;
    bit               done;
    res  = '0;
    len  = (r.key_length > KEY_BYTES) ? LEN_W'(KEY_BYTES) : r.key_length;
    k    = masked_key(r.key, len);
    home = 0;
    for (int i = 0; i < len; i++) home ^= k[8*i +: 8];
    home = home % BUCKETS;

    // Walk the chain until an empty slot, a match or a full lap
    idx  = home;
    done = 1'b0;
    for (int n = 0; n < BUCKETS && !done; n++) begin
      if (!slot_used[idx]) begin
        done = 1'b1;
      end else if (slot_len[idx] == len && slot_key[idx] == k) begin
        res.hit  = 1'b1;
        res.slot = SLOT_W'(idx);
        done     = 1'b1;
      end else begin
        idx = (idx + 1) % BUCKETS;
      end
    end

    if (res.hit) begin
      if (r.operation == OP_DELETE) begin
        slot_used[idx] = 1'b0;
        occupied--;
      end
    end else if (r.operation == OP_INSERT) begin
      // Place in the first empty slot from home, or report full
      idx  = home;
      done = 1'b0;
      for (int n = 0; n < BUCKETS && !done; n++) begin
        if (!slot_used[idx]) begin
          slot_used[idx] = 1'b1;
          slot_len[idx]  = len;
          slot_key[idx]  = k;
          res.slot       = SLOT_W'(idx);
          done           = 1'b1;
          occupied++;
        end else begin
          idx = (idx + 1) % BUCKETS;
        end
      end
      if (!done) res.full_res = 1'b1;
    end
    if (occupied > peak_occupied) peak_occupied = occupied;
    return res;
  endfunction

  // Draw a random request, mostly on known keys with noise in the ignored bytes
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    int unsigned len;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30)      r.operation = OP_LOOKUP;
    else if (roll < 62) r.operation = OP_INSERT;
    else if (roll < 96) r.operation = OP_DELETE;
    else                r.operation = OP_SPARE;
    if (pool_key.size() != 0 && $urandom_range(99) < 70) begin
      pick         = $urandom_range(pool_key.size() - 1);
      len          = pool_len[pick];
      r.key        = pool_key[pick] | ({$urandom, $urandom} & ~masked_key('1, len));
      r.key_length = (len == KEY_BYTES) ? LEN_W'($urandom_range(KEY_BYTES, 15)) : LEN_W'(len);
    end else begin
      r.key_length = LEN_W'($urandom_range(15));
      r.key        = {$urandom, $urandom};
    end
    return r;
  endfunction

  // Hand one request to the block after a random idle gap; queue its answer
  task automatic issue(req_t r, bit typed, res_t want);
    int unsigned gap;
    res_t        got;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    got = apply_request(r);
    expected_res.push_back(typed ? want : got);
    n_sent++;
  endtask

  // Check every strobed result against the oldest pending answer
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_res.size() == 0) begin
        errors++;
        $error("result with no request pending: hit=%0b slot=%0d full_res=%0b",
               out_res.hit, out_res.slot, out_res.full_res);
      end else begin
        head_res = expected_res.pop_front();
        n_results++;
        if (head_res.hit) n_hits++;
        if (head_res.full_res) n_full++;
        if (out_res.hit !== head_res.hit) begin
          errors++;
          $error("hit: expected %0b, got %0b", head_res.hit, out_res.hit);
        end
        if (out_res.slot !== head_res.slot) begin
          errors++;
          $error("slot: expected %0d, got %0d", head_res.slot, out_res.slot);
        end
        if (out_res.full_res !== head_res.full_res) begin
          errors++;
          $error("full_res: expected %0b, got %0b", head_res.full_res, out_res.full_res);
        end
      end
    end
  end

  initial begin
    req_t        r;
    res_t        want;
    int unsigned fill_n;
    int unsigned pct [3];
    pct[0] = 16;
    pct[1] = 79;
    pct[2] = 0;

    // Hold reset low, then release it; the clearing pass shows up as busy
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      r.operation  = DIRECTED[i].op;
      r.key_length = DIRECTED[i].len;
      r.key        = DIRECTED[i].key;
      want         = '0;
      want.hit     = DIRECTED[i].hit;
      want.slot    = DIRECTED[i].slot;
      issue(r, DIRECTED[i].typed, want);
    end

    // Random requests under three idle patterns
    for (int p = 0; p < 3; p++) begin
      idle_pct = pct[p];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = random_request();
        issue(r, 1'b0, '0);
        if (r.operation == OP_INSERT) begin
          if (pool_key.size() < POOL_MAX) begin
            pool_len.push_back((r.key_length > KEY_BYTES) ? LEN_W'(KEY_BYTES) : r.key_length);
            pool_key.push_back(masked_key(r.key, r.key_length));
          end else begin
            fill_n = $urandom_range(POOL_MAX - 1);
            pool_len[fill_n] = (r.key_length > KEY_BYTES) ? LEN_W'(KEY_BYTES) : r.key_length;
            pool_key[fill_n] = masked_key(r.key, r.key_length);
          end
        end
      end
    end
    start <= 1'b0;

    // Drain, then watch for stray results over one worst-case probe
    while (expected_res.size() != 0) @(posedge clk);
    repeat (2 * BUCKETS + 8) @(posedge clk);

    $display("Sent %0d requests (%0d from the directed table), checked %0d answers",
             n_sent, DIR_ROWS, n_results);
    $display("%0d hits, %0d table-full answers, table peaked at %0d of %0d slots",
             n_hits, n_full, peak_occupied, BUCKETS);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #(400_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
